// File: rtl/core/lcfir_pkg.sv
// Shared constants and types for the linear convolution FIR block.
// Depends on nothing; every module of the block imports it.
package lcfir_pkg;

    localparam int TAPS        = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int ACC_BITS    = 40;
    localparam int AW          = $clog2(TAPS);
    localparam int CNT_BITS    = $clog2(TAPS + 1);
    localparam int IDX_BITS    = 5;

    localparam logic [CNT_BITS-1:0] TAP_COUNT_RST = CNT_BITS'(32);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [ACC_BITS-1:0]    t_acc;

    // Coefficient store write from the sequencer.
    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        t_sample       data;
    } t_coef_wr;

    // Per-cycle datapath control from the sequencer.
    typedef struct packed {
        logic          issue;     // start one tap product
        logic          last_tap;  // this product closes the sum
        logic [AW-1:0] idx;       // tap position
        logic          shift;     // shift the current sample into the delay line
        logic          clear;     // zero the delay line
    } t_dp_cmd;

endpackage

// File: rtl/core/lcfir_mac.sv
// Shared multiply-accumulate datapath: coefficient memory, delay line,
// one multiplier and one 40-bit accumulator. Depends on lcfir_pkg.
module lcfir_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcfir_pkg::t_coef_wr i_coef_wr,
    input  lcfir_pkg::t_dp_cmd  i_cmd,
    input  lcfir_pkg::t_sample  i_x,
    output logic               o_done,
    output lcfir_pkg::t_acc     o_acc
);
    import lcfir_pkg::*;

    t_sample                     r_coef_mem [0:TAPS-1];
    t_sample                     r_dl       [0:TAPS-2];
    t_sample                     r_opa;
    t_sample                     r_coef;
    logic signed [PROD_BITS-1:0] r_prod;
    t_acc                        r_acc;
    logic                        r_v1, r_l1, r_f1;
    logic                        r_v2, r_l2, r_f2;
    logic                        r_done;
    t_sample                     opa_sel;
    logic [AW-1:0]               dl_idx;

    assign dl_idx  = i_cmd.idx - AW'(1);
    assign opa_sel = (i_cmd.idx == '0) ? i_x : r_dl[dl_idx];

    // Coefficient memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_coef_wr.we) begin
            r_coef_mem[i_coef_wr.addr] <= i_coef_wr.data;
        end
        r_coef <= r_coef_mem[i_cmd.idx];
    end

    // Delay line: shift the new sample in, or clear after the tail.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < TAPS - 1; k++) begin
                r_dl[k] <= '0;
            end
        end else if (i_cmd.shift) begin
            r_dl[0] <= i_x;
            for (int k = 1; k < TAPS - 1; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // Operand, product and accumulate stages.
    always_ff @(posedge i_clk) begin
        r_opa  <= opa_sel;
        r_prod <= r_opa * r_coef;
        if (r_v2) begin
            r_acc <= (r_f2 ? t_acc'(0) : r_acc) + ACC_BITS'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_l1   <= 1'b0;
            r_l2   <= 1'b0;
            r_f1   <= 1'b0;
            r_f2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_cmd.issue;
            r_l1   <= i_cmd.issue & i_cmd.last_tap;
            r_f1   <= i_cmd.idx == '0;
            r_v2   <= r_v1;
            r_l2   <= r_l1;
            r_f2   <= r_f1;
            r_done <= r_v2 & r_l2;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// File: rtl/core/lcfir_seq.sv
// Sequencer: takes input transfers, steps the shared MAC through the taps,
// runs the tail and holds the output register. Depends on lcfir_pkg.
module lcfir_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [lcfir_pkg::IDX_BITS-1:0]  i_coef_index,
    input  lcfir_pkg::t_sample              i_value,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lcfir_pkg::t_acc                 o_acc,
    output logic                            o_out_last,
    input  logic [lcfir_pkg::AW-1:0]        i_last_idx,
    input  logic                            i_done,
    input  lcfir_pkg::t_acc                 i_mac_acc,
    output lcfir_pkg::t_coef_wr             o_coef_wr,
    output lcfir_pkg::t_dp_cmd              o_cmd,
    output lcfir_pkg::t_sample              o_x
);
    import lcfir_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} t_state;

    t_state              r_state;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       r_tail;
    logic                r_lastflag;
    t_sample             r_x;
    t_acc                r_acc;
    logic                r_out_last;
    logic                accept;
    logic                final_out;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign final_out = r_lastflag && (r_tail == '0);

    always_comb begin
        o_coef_wr.we   = accept && (i_mode == MODE_LOAD) &&
                         (CNT_BITS'(i_coef_index) < CNT_BITS'(TAPS));
        o_coef_wr.addr = AW'(i_coef_index);
        o_coef_wr.data = i_value;

        o_cmd.issue    = r_state == S_ISSUE;
        o_cmd.last_tap = r_idx == i_last_idx;
        o_cmd.idx      = r_idx;
        o_cmd.shift    = (r_state == S_WAIT) && i_done && !final_out;
        o_cmd.clear    = (r_state == S_WAIT) && i_done && final_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_tail     <= '0;
            r_lastflag <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_mode == MODE_SAMPLE)) begin
                        r_x        <= i_value;
                        r_lastflag <= i_last;
                        r_tail     <= i_last ? i_last_idx : '0;
                        r_idx      <= '0;
                        r_state    <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_idx == i_last_idx) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_WAIT: begin
                    if (i_done) begin
                        r_acc      <= i_mac_acc;
                        r_out_last <= final_out;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        if (r_tail != '0) begin
                            // next tail output: a zero sample goes in
                            r_tail  <= r_tail - AW'(1);
                            r_x     <= '0;
                            r_idx   <= '0;
                            r_state <= S_ISSUE;
                        end else begin
                            r_lastflag <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_state == S_OUT;
    assign o_acc       = r_acc;
    assign o_out_last  = r_out_last;
    assign o_x         = r_x;

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> (r_state == S_WAIT))
        else $error("MAC finished a sum outside the wait state");

    a_no_coef_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_coef_wr.we |-> !o_in_stall)
        else $error("coefficient written while a sample is in progress");

    a_tail_step_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (r_tail != '0)) |=>
            (r_tail == $past(r_tail) - AW'(1)) && (r_state == S_ISSUE))
        else $error("tail count did not step down on a tail transfer");

    a_clear_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> (r_lastflag && !o_cmd.shift))
        else $error("delay line cleared outside the final output");

endmodule

// File: rtl/core/linear_convolution_fir_top.sv
// Top level of the linear convolution FIR: tap count register, tap clamp,
// and the sequencer and MAC datapath. Depends on lcfir_pkg, lcfir_seq, lcfir_mac.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): a transfer with i_mode = 0 writes
//   i_value into coefficient slot i_coef_index and produces no output. A
//   transfer with i_mode = 1 is a Q1.15 sample x[n]; it produces one Q10.30
//   result y[n] = sum x[n-j]*h[j] over the taps in use. With i_last high the
//   sample is followed by tap_count-1 tail results and the delay line is then
//   cleared; the final result carries o_out_last.
//   Output channel (o_out_valid / i_out_stall): one result sits in the output
//   register; hold it while i_out_stall is high.
//   Throughput: one shared 16x16 multiplier does one tap per cycle, so each
//   result goes from the input transfer (or from the transfer of the previous
//   tail result) to o_out_valid through the issue of every tap in use, then
//   the operand, product and accumulate stages, and waits longer while the
//   receiver stalls. A load transfer does not stall the input channel.
//   o_in_stall stays high from a sample transfer until its last result,
//   tail included, has been transferred.
//   Configuration: i_cfg_wr_en writes tap_count (0 acts as 1, above 32 as 32);
//   write it only while the block is idle.
//   Reset: synchronous, active low; clears the delay line, sets tap_count to
//   32. Coefficients are undefined until loaded.
module linear_convolution_fir_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lcfir_pkg::CNT_BITS-1:0]  i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [lcfir_pkg::IDX_BITS-1:0]  i_coef_index,
    input  lcfir_pkg::t_sample              i_value,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lcfir_pkg::t_acc                 o_acc,
    output logic                            o_out_last
);
    import lcfir_pkg::*;

    logic [CNT_BITS-1:0] r_tap_count;
    logic [CNT_BITS-1:0] taps_eff;
    logic [AW-1:0]       last_idx;
    t_coef_wr            coef_wr;
    t_dp_cmd             cmd;
    t_sample             x;
    logic                done;
    t_acc                mac_acc;

    // Hold the tap count; the user must write it only while idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_tap_count <= i_cfg_wr_data;
        end
    end

    // Clamp the tap count into 1..TAPS and turn it into the last tap index.
    always_comb begin
        if (r_tap_count == '0) begin
            taps_eff = CNT_BITS'(1);
        end else if (r_tap_count > CNT_BITS'(TAPS)) begin
            taps_eff = CNT_BITS'(TAPS);
        end else begin
            taps_eff = r_tap_count;
        end
        last_idx = AW'(taps_eff - CNT_BITS'(1));
    end

    lcfir_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_coef_index (i_coef_index),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_acc        (o_acc),
        .o_out_last   (o_out_last),
        .i_last_idx   (last_idx),
        .i_done       (done),
        .i_mac_acc    (mac_acc),
        .o_coef_wr    (coef_wr),
        .o_cmd        (cmd),
        .o_x          (x)
    );

    lcfir_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_coef_wr (coef_wr),
        .i_cmd     (cmd),
        .i_x       (x),
        .o_done    (done),
        .o_acc     (mac_acc)
    );

endmodule

// File: tb/tb_linear_convolution_fir_top.sv
// Self-checking bench for linear_convolution_fir_top: directed tap-count corners, then
// random coefficient sets and signals, each result checked against a local predictor.
// Depends on lcfir_pkg and the RTL of linear_convolution_fir_top.
`timescale 1ns / 1ps

module tb_linear_convolution_fir_top;
    import lcfir_pkg::*;

    // One expected output sample of the convolution.
    typedef struct {
        t_acc acc;
        logic last;
    } t_y_item;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CNT_BITS-1:0]  i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_mode;
    logic [IDX_BITS-1:0]  i_coef_index;
    t_sample              i_value;
    logic                 i_last;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_acc                 o_acc;
    logic                 o_out_last;

    // Predictor state: coefficient store, delay line (x[n-1] first) and tap count.
    t_sample              coef_model[TAPS];
    bit [TAPS-1:0]        coef_loaded = '0;
    t_sample              history[TAPS-1];
    logic [CNT_BITS-1:0]  tap_count_reg = TAP_COUNT_RST;

    t_y_item              expected_y[$];
    int                   err_count = 0;
    int                   items_sent = 0;
    int                   stall_left = 0;
    bit                   burst = 1'b0;

    linear_convolution_fir_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_coef_index  (i_coef_index),
        .i_value       (i_value),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_acc         (o_acc),
        .o_out_last    (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (every sample with a full
    // 32-tap tail and every result stalled for the longest draw).
    initial begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp the register the way the block does: 0 acts as 1, above TAPS as TAPS.
    function automatic int taps_active();
        if (tap_count_reg == 0)
            return 1;
        if (tap_count_reg > TAPS)
            return TAPS;
        return tap_count_reg;
    endfunction

    // Sum x[n-j]*h[j] over the taps in use, then shift x into the delay line.
    // The exact sum fits in 64 bits; keep the low 40.
    function automatic t_acc mac_and_advance(t_sample x, int n);
        longint sum;
        sum = longint'(x) * longint'(coef_model[0]);
        for (int j = 1; j < n; j++)
            sum += longint'(history[j-1]) * longint'(coef_model[j]);
        for (int j = TAPS - 2; j > 0; j--)
            history[j] = history[j-1];
        history[0] = x;
        return t_acc'(sum);
    endfunction

    // Apply one accepted transfer: loads update the store, samples queue their outputs.
    function automatic void convolve_transfer(logic mode, logic [IDX_BITS-1:0] idx,
                                              t_sample value, logic last);
        int      n;
        t_y_item y;
        n = taps_active();
        if (mode == MODE_LOAD) begin
            if (idx < TAPS) begin
                coef_model[idx]  = value;
                coef_loaded[idx] = 1'b1;
            end
            return;
        end
        y.acc  = mac_and_advance(value, n);
        y.last = last && (n == 1);
        expected_y.push_back(y);
        if (last) begin
            // Tail: flush the delay line with zeros, flag the final output.
            for (int left = n - 1; left > 0; left--) begin
                y.acc  = mac_and_advance('0, n);
                y.last = (left == 1);
                expected_y.push_back(y);
            end
            foreach (history[i])
                history[i] = '0;
        end
    endfunction

    // Bias towards the Q1.15 extremes and zero.
    function automatic t_sample draw_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic void note_error(string msg);
        $display("%0t: %s", $time, msg);
        err_count++;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall per result, check each transfer in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_y_item want;
        int      hold;
        if (!i_rst_n) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            if (expected_y.size() == 0) begin
                note_error($sformatf("unexpected result: expected none, %s %0d last %0b",
                                     "actual acc", o_acc, o_out_last));
            end else begin
                want = expected_y.pop_front();
                if (o_acc !== want.acc)
                    note_error($sformatf("acc mismatch: expected %0d, actual %0d",
                                         want.acc, o_acc));
                if (o_out_last !== want.last)
                    note_error($sformatf("out_last mismatch: expected %0b, actual %0b",
                                         want.last, o_out_last));
            end
            // Draw the stall that precedes the next result.
            hold        = burst ? 0 : $urandom_range(0, 19);
            stall_left  <= hold;
            i_out_stall <= (hold != 0);
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_left > 1);
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks (always entered and left at a rising edge)
    // ------------------------------------------------------------------

    // Drive one input transfer after a random gap and predict it once accepted.
    // Leave valid high afterwards so back-to-back transfers need no extra edge.
    task automatic send_transfer(logic mode, logic [IDX_BITS-1:0] idx, t_sample value,
                                 logic last);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_coef_index <= idx;
        i_value      <= value;
        i_last       <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        convolve_transfer(mode, idx, value, last);
        items_sent++;
    endtask

    // Drop valid, hold until every queued output has been transferred, then settle.
    task automatic wait_drained(int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_y.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write tap_count only once the block has gone quiet; a load still in
    // flight has no result to wait for, so allow a full result latency.
    task automatic write_tap_count(logic [CNT_BITS-1:0] setting);
        wait_drained(TAPS + 8);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= setting;
        @(posedge i_clk);
        tap_count_reg = setting;
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Load any coefficient in use that has never been written.
    task automatic fill_coefficients(int n);
        for (int i = 0; i < n; i++)
            if (!coef_loaded[i])
                send_transfer(MODE_LOAD, IDX_BITS'(i), draw_value(), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Four taps with extreme coefficients and samples, a load to the top
    // slot with last set (must be ignored), and two signals with tails.
    task automatic test_four_taps();
        write_tap_count(CNT_BITS'(4));
        send_transfer(MODE_LOAD, 5'd0, 16'sh8000, 1'b0);
        send_transfer(MODE_LOAD, 5'd1, 16'sh7FFF, 1'b0);
        send_transfer(MODE_LOAD, 5'd2, -16'sd1, 1'b0);
        send_transfer(MODE_LOAD, 5'd3, 16'sd1, 1'b0);
        send_transfer(MODE_LOAD, 5'd31, 16'sh1234, 1'b1);
        send_transfer(MODE_SAMPLE, 5'd31, 16'sh8000, 1'b0);
        send_transfer(MODE_SAMPLE, 5'd0, 16'sh8000, 1'b0);
        send_transfer(MODE_SAMPLE, 5'd0, 16'sh7FFF, 1'b0);
        send_transfer(MODE_SAMPLE, 5'd0, 16'sd0, 1'b0);
        send_transfer(MODE_SAMPLE, 5'd0, -16'sd1, 1'b1);
        send_transfer(MODE_SAMPLE, 5'd0, 16'sh8000, 1'b1);
    endtask

    // Single tap: every output of a last sample is itself the final one;
    // a register value of zero must behave as one tap.
    task automatic test_single_tap();
        write_tap_count(CNT_BITS'(1));
        send_transfer(MODE_SAMPLE, 5'd0, 16'sh7FFF, 1'b1);
        send_transfer(MODE_SAMPLE, 5'd0, 16'sh8000, 1'b0);
        send_transfer(MODE_SAMPLE, 5'd0, 16'sd5, 1'b1);
        write_tap_count(CNT_BITS'(0));
        send_transfer(MODE_SAMPLE, 5'd0, 16'sh8000, 1'b1);
    endtask

    // Phases of: tap-count write, coefficient refresh, one signal. The first
    // phases walk the register extremes, later ones favour short filters.
    task automatic test_random_signals();
        logic [CNT_BITS-1:0] setting;
        int                  n;
        int                  len;
        int                  phase;
        phase = 0;
        while (items_sent < 370) begin
            case (phase)
                0:       setting = CNT_BITS'(32);
                1:       setting = CNT_BITS'(63);
                2:       setting = CNT_BITS'(33);
                3:       setting = CNT_BITS'(31);
                4:       setting = CNT_BITS'(0);
                default: setting = ($urandom_range(0, 9) < 7) ? CNT_BITS'($urandom_range(1, 8))
                                                               : CNT_BITS'($urandom_range(0, 63));
            endcase
            burst = ($urandom_range(0, 3) == 0);
            write_tap_count(setting);
            n = taps_active();
            // Random last bit on loads; the block ignores it.
            repeat ($urandom_range(0, n))
                send_transfer(MODE_LOAD, IDX_BITS'($urandom_range(0, TAPS - 1)), draw_value(),
                              1'($urandom_range(0, 1)));
            fill_coefficients(n);
            len = $urandom_range(1, 10);
            for (int s = 0; s < len; s++) begin
                // Stray coefficient load inside a signal.
                if ($urandom_range(0, 9) == 0)
                    send_transfer(MODE_LOAD, IDX_BITS'($urandom_range(0, TAPS - 1)),
                                  draw_value(), 1'($urandom_range(0, 1)));
                // Hold the sender until everything owed has come out.
                if ($urandom_range(0, 9) == 0)
                    wait_drained(0);
                send_transfer(MODE_SAMPLE, IDX_BITS'($urandom), draw_value(),
                              (s == len - 1) && ($urandom_range(0, 7) != 0));
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (coef_model[i])
            coef_model[i] = '0;
        foreach (history[i])
            history[i] = '0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_mode        <= MODE_LOAD;
        i_coef_index  <= '0;
        i_value       <= '0;
        i_last        <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_four_taps();
        test_single_tap();
        test_random_signals();

        wait_drained(TAPS + 8);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/core/lcfir_pkg.sv
rtl/core/lcfir_mac.sv
rtl/core/lcfir_seq.sv
rtl/core/linear_convolution_fir_top.sv
tb/tb_linear_convolution_fir_top.sv
